FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included.
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("assertion failed");

// Check outside reset only.
`define ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

`endif

FILE: hdl/rrtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table package
// Word types, slot states, op and status codes shared by the block.
// ----------------------------------------------------------------------------
package rrtt_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_YIELD  = 2'd1;
   localparam logic [1:0] OP_EXIT   = 2'd2;
   localparam logic [1:0] OP_REAP   = 2'd3;

   localparam logic [1:0] ST_UNUSED     = 2'd0;
   localparam logic [1:0] ST_READY      = 2'd1;
   localparam logic [1:0] ST_RUNNING    = 2'd2;
   localparam logic [1:0] ST_TERMINATED = 2'd3;

   localparam logic [1:0] RSP_DONE       = 2'd0;
   localparam logic [1:0] RSP_REJECTED   = 2'd1;
   localparam logic [1:0] RSP_NONE_READY = 2'd2;
   localparam logic [1:0] RSP_HALTED     = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] dir_base;
      logic [31:0] entry_address;
      logic [3:0]  target_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  affected_slot;
      logic [31:0] task_id;
      logic        switched;
      logic [3:0]  current_slot;
      logic [31:0] current_dir_base;
      logic [31:0] current_entry;
   } rsp_type;

   // Request word after classification in the front end.
   typedef struct packed {
      req_type item;
      logic    entry_zero;
      logic    target_ok;
   } work_type;

   typedef struct packed {
      logic [31:0] task_id;
      logic [31:0] directory;
      logic [31:0] entry;
   } slot_rec_type;

endpackage

FILE: hdl/rrtt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table front end
// Two-word request queue; classifies the head word for the engine.
// ----------------------------------------------------------------------------
module rrtt_front #(
   parameter int SLOTS = rrtt_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rrtt_pkg::req_type req_word,
   output logic              work_valid,
   output rrtt_pkg::work_type work,
   input  logic              work_take
);
   import rrtt_pkg::*;

   req_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok, take_ok;
   req_type    head;

   assign req_full   = (count_ff == 2'd2);
   assign work_valid = (count_ff != 2'd0);
   assign push_ok    = req_push && !req_full;
   assign take_ok    = work_take && work_valid;
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      work.item       = head;
      work.entry_zero = (head.entry_address == 32'd0);
      work.target_ok  = (int'(head.target_slot) < SLOTS);
   end

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, take_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

FILE: hdl/rrtt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table engine
// Slot table, scan sequencer and result register.
// ----------------------------------------------------------------------------
module rrtt_engine #(
   parameter int SLOTS = rrtt_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data,
   input  logic               work_valid,
   input  rrtt_pkg::work_type work,
   output logic               work_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rrtt_pkg::rsp_type  rsp_word
);
   import rrtt_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_SWITCH = 3'd2;
   localparam logic [2:0] S_CUR    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]    seq_ff, seq_in;
   work_type      work_ff;
   logic [IW-1:0] running_ff, running_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [IW-1:0] off_ff, off_in;
   logic          halted_ff, halted_in;
   logic [31:0]   dir0_ff, dir0_in;
   logic [31:0]   next_id_ff, next_id_in;
   logic [1:0]    status_ff, status_in;
   logic [3:0]    affected_ff, affected_in;
   logic [31:0]   task_id_ff, task_id_in;
   logic          switched_ff, switched_in;
   logic          need_id_ff, need_id_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_load;

   logic [1:0]    slot_state_ff [SLOTS];
   logic          st_we;
   logic [IW-1:0] st_wa;
   logic [1:0]    st_wd;
   logic [IW-1:0] st_ra;
   logic [1:0]    st_rd;

   slot_rec_type  mem [SLOTS];
   slot_rec_type  rd_data_ff;
   logic          mem_we;
   slot_rec_type  mem_wd;

   logic [IW:0]   wrap_sum;
   logic [IW-1:0] scan_idx;
   logic [IW-1:0] tgt_idx;
   slot_rec_type  cur_rec;

   assign csr_ready = 1'b1;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign rsp_load  = (seq_ff == S_DONE) && (!rsp_valid_ff || rsp_pop);
   assign work_take = (seq_ff == S_IDLE) && work_valid;
   assign tgt_idx   = IW'(work.item.target_slot);

   // round-robin candidate: running + offset, modulo the table depth; a create scans by the offset alone
   always_comb begin
      wrap_sum = {1'b0, running_ff} + {1'b0, off_ff};
      if (wrap_sum >= (IW+1)'(SLOTS)) begin
         wrap_sum = wrap_sum - (IW+1)'(SLOTS);
      end
      scan_idx = (work_ff.item.op == OP_CREATE) ? off_ff : wrap_sum[IW-1:0];
   end

   assign st_ra = (seq_ff == S_IDLE) ? tgt_idx : scan_idx;
   assign st_rd = slot_state_ff[st_ra];

   // slot 0 never holds a created task: its id and entry stay zero
   always_comb begin
      cur_rec = rd_data_ff;
      if (running_ff == '0) begin
         cur_rec.task_id   = 32'd0;
         cur_rec.directory = dir0_ff;
         cur_rec.entry     = 32'd0;
      end
   end

   always_comb begin
      seq_in      = seq_ff;
      running_in  = running_ff;
      prev_in     = prev_ff;
      off_in      = off_ff;
      halted_in   = halted_ff;
      dir0_in     = dir0_ff;
      next_id_in  = next_id_ff;
      status_in   = status_ff;
      affected_in = affected_ff;
      task_id_in  = task_id_ff;
      switched_in = switched_ff;
      need_id_in  = need_id_ff;
      st_we       = 1'b0;
      st_wa       = running_ff;
      st_wd       = ST_UNUSED;
      mem_we      = 1'b0;
      mem_wd      = '{task_id: next_id_ff,
                      directory: work_ff.item.dir_base,
                      entry: work_ff.item.entry_address};

      if (csr_valid) begin
         dir0_in = csr_data;
      end

      unique case (seq_ff)
         S_IDLE: begin
            if (work_valid) begin
               off_in      = IW'(1);
               switched_in = 1'b0;
               need_id_in  = 1'b0;
               task_id_in  = 32'd0;
               affected_in = 4'(running_ff);
               prev_in     = running_ff;
               if (halted_ff) begin
                  status_in = RSP_HALTED;
                  seq_in    = S_CUR;
               end else begin
                  unique case (work.item.op)
                     OP_CREATE: begin
                        if (work.entry_zero) begin
                           status_in   = RSP_REJECTED;
                           affected_in = 4'd0;
                           seq_in      = S_CUR;
                        end else begin
                           seq_in = S_SCAN;
                        end
                     end
                     OP_YIELD: begin
                        seq_in = S_SCAN;
                     end
                     OP_EXIT: begin
                        st_we  = 1'b1;
                        st_wa  = running_ff;
                        st_wd  = ST_TERMINATED;
                        seq_in = S_SCAN;
                     end
                     default: begin
                        affected_in = work.item.target_slot;
                        seq_in      = S_CUR;
                        if (!work.target_ok || tgt_idx == running_ff ||
                            st_rd != ST_TERMINATED) begin
                           status_in = RSP_REJECTED;
                        end else begin
                           status_in = RSP_DONE;
                           st_we     = 1'b1;
                           st_wa     = tgt_idx;
                           st_wd     = ST_UNUSED;
                           if (tgt_idx == '0) begin
                              dir0_in = 32'd0;
                           end
                        end
                     end
                  endcase
               end
            end
         end

         S_SCAN: begin
            if (work_ff.item.op == OP_CREATE) begin
               if (st_rd == ST_UNUSED) begin
                  mem_we      = 1'b1;
                  st_we       = 1'b1;
                  st_wa       = scan_idx;
                  st_wd       = ST_READY;
                  task_id_in  = next_id_ff;
                  next_id_in  = next_id_ff + 32'd1;
                  status_in   = RSP_DONE;
                  affected_in = 4'(scan_idx);
                  seq_in      = S_CUR;
               end else if (off_ff == IW'(SLOTS - 1)) begin
                  status_in   = RSP_REJECTED;
                  affected_in = 4'd0;
                  seq_in      = S_CUR;
               end else begin
                  off_in = off_ff + IW'(1);
               end
            end else if (st_rd == ST_READY) begin
               st_we       = 1'b1;
               st_wa       = scan_idx;
               st_wd       = ST_RUNNING;
               running_in  = scan_idx;
               status_in   = RSP_DONE;
               switched_in = 1'b1;
               need_id_in  = 1'b1;
               seq_in      = S_SWITCH;
            end else if (off_ff == IW'(SLOTS - 1)) begin
               if (work_ff.item.op == OP_YIELD) begin
                  status_in  = RSP_NONE_READY;
                  need_id_in = 1'b1;
               end else begin
                  halted_in = 1'b1;
                  status_in = RSP_HALTED;
               end
               seq_in = S_CUR;
            end else begin
               off_in = off_ff + IW'(1);
            end
         end

         S_SWITCH: begin
            // hand the previous slot back to the ready pool on a yield
            if (work_ff.item.op == OP_YIELD) begin
               st_we = 1'b1;
               st_wa = prev_ff;
               st_wd = ST_READY;
            end
            seq_in = S_CUR;
         end

         S_CUR: begin
            seq_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_load) begin
               seq_in = S_IDLE;
            end
         end

         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         running_ff   <= '0;
         halted_ff    <= 1'b0;
         dir0_ff      <= 32'd0;
         next_id_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_state_ff[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
         end
      end else begin
         seq_ff     <= seq_in;
         running_ff <= running_in;
         halted_ff  <= halted_in;
         dir0_ff    <= dir0_in;
         next_id_ff <= next_id_in;
         if (st_we) begin
            slot_state_ff[st_wa] <= st_wd;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      off_ff      <= off_in;
      status_ff   <= status_in;
      affected_ff <= affected_in;
      task_id_ff  <= task_id_in;
      switched_ff <= switched_in;
      need_id_ff  <= need_id_in;
      if (work_take) begin
         work_ff <= work;
      end
      if (rsp_load) begin
         rsp_ff.status           <= status_ff;
         rsp_ff.affected_slot    <= affected_ff;
         rsp_ff.task_id          <= need_id_ff ? cur_rec.task_id : task_id_ff;
         rsp_ff.switched         <= switched_ff;
         rsp_ff.current_slot     <= 4'(running_ff);
         rsp_ff.current_dir_base <= cur_rec.directory;
         rsp_ff.current_entry    <= cur_rec.entry;
      end
   end

   // slot record memory, read at the running slot every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[scan_idx] <= mem_wd;
      end
      rd_data_ff <= mem[running_ff];
   end

endmodule

FILE: hdl/round_robin_task_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table
// Task slot table with create, yield, exit and reap, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter through req_push/req_full into a two-word queue; a request
//    is taken when req_push is high and req_full low.
//  - Responses leave through rsp_empty/rsp_pop; the oldest response sits on
//    rsp_word while rsp_empty is low and leaves when rsp_pop is high.
//  - csr_valid/csr_ready writes the boot page directory (slot 0); csr_ready
//    is always high. Write it only while no request is in flight.
//  - The engine handles one request at a time. Reap, rejected create and
//    halted requests skip the scan; create, yield and exit scan the slot
//    table one slot a cycle, over every other slot at most. This single
//    slot-state scan sets the length of a request.
//  - A held response stalls the engine; the request queue still takes up to
//    two words meanwhile.
//  - Reset: slot 0 running with id 0, other slots unused, next id 1, queue
//    and response register empty.
// ----------------------------------------------------------------------------
module round_robin_task_table #(
   parameter int SLOTS = rrtt_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rrtt_pkg::req_type req_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rrtt_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import rrtt_pkg::*;

   work_type work;
   logic     work_valid;
   logic     work_take;

   rrtt_front #(.SLOTS(SLOTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .work_valid (work_valid),
      .work       (work),
      .work_take  (work_take)
   );

   rrtt_engine #(.SLOTS(SLOTS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .work_valid (work_valid),
      .work       (work),
      .work_take  (work_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

endmodule

FILE: hdl/rrtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrtt_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input rrtt_pkg::rsp_type rsp_word
);
   import rrtt_pkg::*;

   // nothing waits on the response side straight after reset
   `ASSERT_CLK(a_empty_after_reset, reset |=> rsp_empty)
   // hold a waiting word until it is popped
   `ASSERT_RST(a_hold_word, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
   `ASSERT_RST(a_switch_done, !rsp_empty && rsp_word.switched |-> rsp_word.status == RSP_DONE)
   `ASSERT_RST(a_halt_no_id, !rsp_empty && rsp_word.status == RSP_HALTED |-> rsp_word.task_id == 32'd0 && !rsp_word.switched)
   `ASSERT_RST(a_reject_no_id, !rsp_empty && rsp_word.status == RSP_REJECTED |-> rsp_word.task_id == 32'd0)

endmodule

bind round_robin_task_table rrtt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table testbench
// Drives create, yield, exit and reap words in random bursts, predicts each
// response from a local copy of the slot table and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
   import rrtt_pkg::*;

   localparam int NSLOTS    = 16;
   localparam int IDLE_WAIT = 40;
   localparam int WD_LIMIT  = 20000;
   localparam int LONG_HOLD = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_word = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_word;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [31:0] csr_data = '0;

   round_robin_task_table #(.SLOTS(NSLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Predicted table
   logic [1:0]  tbl_state [NSLOTS];
   logic [31:0] tbl_id    [NSLOTS];
   logic [31:0] tbl_dir   [NSLOTS];
   logic [31:0] tbl_entry [NSLOTS];
   logic [3:0]  cur_slot;
   logic [31:0] id_counter;
   logic        is_halted;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   int      sent = 0;
   int      received = 0;
   bit      drain_hold = 1'b0;
   bit      long_hold = 1'b0;
   bit      hold_done = 1'b0;

   function automatic void table_reset();
      for (int i = 0; i < NSLOTS; i++) begin
         tbl_state[i] = ST_UNUSED;
         tbl_id[i] = '0;
         tbl_dir[i] = '0;
         tbl_entry[i] = '0;
      end
      tbl_state[0] = ST_RUNNING;
      cur_slot = '0;
      id_counter = 32'd1;
      is_halted = 1'b0;
   endfunction

   function automatic int next_ready();
      int idx;
      for (int off = 1; off < NSLOTS; off++) begin
         idx = (cur_slot + off) % NSLOTS;
         if (tbl_state[idx] == ST_READY) return idx;
      end
      return NSLOTS;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] st, logic [3:0] aff,
                                        logic [31:0] id, logic sw);
      rsp_type r;
      r.status = st;
      r.affected_slot = aff;
      r.task_id = id;
      r.switched = sw;
      r.current_slot = cur_slot;
      r.current_dir_base = tbl_dir[cur_slot];
      r.current_entry = tbl_entry[cur_slot];
      return r;
   endfunction

   function automatic rsp_type schedule_step(req_type q);
      int nxt;
      logic [3:0] prev;
      logic [31:0] id;
      if (is_halted) return make_rsp(RSP_HALTED, cur_slot, '0, 1'b0);
      case (q.op)
         OP_CREATE: begin
            if (q.entry_address != 0)
               for (int i = 1; i < NSLOTS; i++)
                  if (tbl_state[i] == ST_UNUSED) begin
                     id = id_counter;
                     id_counter = id_counter + 1;
                     tbl_id[i] = id;
                     tbl_state[i] = ST_READY;
                     tbl_dir[i] = q.dir_base;
                     tbl_entry[i] = q.entry_address;
                     return make_rsp(RSP_DONE, i[3:0], id, 1'b0);
                  end
            return make_rsp(RSP_REJECTED, '0, '0, 1'b0);
         end
         OP_YIELD: begin
            nxt = next_ready();
            if (nxt >= NSLOTS)
               return make_rsp(RSP_NONE_READY, cur_slot, tbl_id[cur_slot], 1'b0);
            prev = cur_slot;
            tbl_state[prev] = ST_READY;
            tbl_state[nxt] = ST_RUNNING;
            cur_slot = nxt[3:0];
            return make_rsp(RSP_DONE, prev, tbl_id[nxt], 1'b1);
         end
         OP_EXIT: begin
            prev = cur_slot;
            tbl_state[prev] = ST_TERMINATED;
            nxt = next_ready();
            if (nxt >= NSLOTS) begin
               is_halted = 1'b1;
               return make_rsp(RSP_HALTED, prev, '0, 1'b0);
            end
            tbl_state[nxt] = ST_RUNNING;
            cur_slot = nxt[3:0];
            return make_rsp(RSP_DONE, prev, tbl_id[nxt], 1'b1);
         end
         default: begin
            if (q.target_slot >= NSLOTS || q.target_slot == cur_slot ||
                tbl_state[q.target_slot] != ST_TERMINATED)
               return make_rsp(RSP_REJECTED, q.target_slot, '0, 1'b0);
            tbl_state[q.target_slot] = ST_UNUSED;
            tbl_id[q.target_slot] = '0;
            tbl_dir[q.target_slot] = '0;
            tbl_entry[q.target_slot] = '0;
            return make_rsp(RSP_DONE, q.target_slot, '0, 1'b0);
         end
      endcase
   endfunction

   // Driver: bursts of pushes with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_rsps.push_back(schedule_step(req_word));
            sent <= sent + 1;
         end
         if (!(req_push && req_full)) begin
            if (pending_reqs.size() > 0 && !drain_hold && gap_left == 0) begin
               req_push <= 1'b1;
               req_word <= pending_reqs.pop_front();
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_push <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // Monitor: stalls on its own pattern, compares each popped word
   int stall_phase = 0;
   int hold_count = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            received <= received + 1;
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_word.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_word.status); errors++;
               end
               if (rsp_word.affected_slot !== e.affected_slot) begin
                  $error("affected_slot exp %0d got %0d", e.affected_slot,
                         rsp_word.affected_slot); errors++;
               end
               if (rsp_word.task_id !== e.task_id) begin
                  $error("task_id exp %0h got %0h", e.task_id, rsp_word.task_id); errors++;
               end
               if (rsp_word.switched !== e.switched) begin
                  $error("switched exp %0d got %0d", e.switched, rsp_word.switched); errors++;
               end
               if (rsp_word.current_slot !== e.current_slot) begin
                  $error("current_slot exp %0d got %0d", e.current_slot,
                         rsp_word.current_slot); errors++;
               end
               if (rsp_word.current_dir_base !== e.current_dir_base) begin
                  $error("current_dir_base exp %0h got %0h",
                         e.current_dir_base, rsp_word.current_dir_base);
                  errors++;
               end
               if (rsp_word.current_entry !== e.current_entry) begin
                  $error("current_entry exp %0h got %0h", e.current_entry,
                         rsp_word.current_entry); errors++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         if (long_hold && !hold_done) begin
            // hold off for a counted stretch so the block fills up
            rsp_pop <= 1'b0;
            hold_count++;
            if (hold_count >= LONG_HOLD) hold_done = 1'b1;
         end
         else if (stall_phase < 24) rsp_pop <= 1'b1;
         else if (stall_phase < 44) rsp_pop <= ($urandom_range(0, 2) != 0);
         else rsp_pop <= ($urandom_range(0, 3) == 0);
      end
   end

   // Watchdog on cycles with no handshake
   int quiet_cycles = 0;
   int last_accepted = 0;
   always @(posedge clock) begin
      if (sent + received != last_accepted) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      last_accepted <= sent + received;
      if (quiet_cycles > WD_LIMIT) begin
         $display("[round_robin_task_table] ERROR");
         $finish;
      end
   end

   function automatic req_type rand_req(logic [1:0] op);
      req_type q;
      q.op = op;
      q.dir_base = $urandom;
      q.entry_address = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
      q.target_slot = $urandom_range(0, 15);
      return q;
   endfunction

   function automatic req_type make_req(logic [1:0] op, logic [31:0] pd,
                                        logic [31:0] ea, logic [3:0] ts);
      req_type q;
      q.op = op;
      q.dir_base = pd;
      q.entry_address = ea;
      q.target_slot = ts;
      return q;
   endfunction

   task automatic wait_drain();
      while (pending_reqs.size() > 0 || req_push || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_boot_dir(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tbl_dir[0] = v;
   endtask

   // Random phase: mostly create/yield/exit/reap mixes that keep the table live
   task automatic random_phase(int count);
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: op = OP_CREATE;
            3, 4, 5: op = OP_YIELD;
            6: op = OP_EXIT;
            default: op = OP_REAP;
         endcase
         pending_reqs.push_back(rand_req(op));
      end
   endtask

   initial begin
      table_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 1: boot directory at max, directed corners
      write_boot_dir(32'hFFFF_FFFF);
      pending_reqs.push_back(make_req(OP_YIELD, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_CREATE, 32'h1234, 32'd0, '0));
      pending_reqs.push_back(make_req(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
      pending_reqs.push_back(make_req(OP_CREATE, '0, 32'd1, '0));
      pending_reqs.push_back(make_req(OP_REAP, '0, '0, 4'd0));
      pending_reqs.push_back(make_req(OP_REAP, '0, '0, 4'd1));
      pending_reqs.push_back(make_req(OP_YIELD, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_EXIT, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_REAP, '0, '0, 4'd0));
      pending_reqs.push_back(make_req(OP_REAP, '0, '0, 4'd15));
      for (int i = 0; i < 15; i++)
         pending_reqs.push_back(make_req(OP_CREATE, $urandom, $urandom | 1, '0));
      wait_drain();

      // Receiver holds off while the sender keeps pushing
      long_hold = 1'b1;
      random_phase(12);
      wait (hold_done);
      long_hold = 1'b0;
      wait_drain();

      // Exit everything until halted, then ops while halted
      for (int i = 0; i < 18; i++)
         pending_reqs.push_back(make_req(OP_EXIT, '0, '0, '0));
      pending_reqs.push_back(rand_req(OP_CREATE));
      pending_reqs.push_back(rand_req(OP_REAP));
      pending_reqs.push_back(rand_req(OP_YIELD));
      wait_drain();

      // Further phases need a fresh table; reset only once, so directory writes
      // remain valid here as the halted block still reports slot directories
      write_boot_dir(32'h0000_0000);
      pending_reqs.push_back(rand_req(OP_YIELD));
      wait_drain();

      // Halted now; random traffic still checks the halted answer and wraps up
      write_boot_dir($urandom);
      random_phase(40);
      wait_drain();

      // Id wrap and broad coverage cannot be reached after halt in one run;
      // keep the remaining random traffic for the halted path
      random_phase(520);
      wait_drain();

      if (errors == 0) $display("[round_robin_task_table] OK");
      else $display("[round_robin_task_table] ERROR");
      $finish;
   end
endmodule
